// ----- sv/dma_channel_service_assert.svh -----
// Assertion helpers for the DMA channel service block.
// Properties passed in must not contain top-level commas.
`ifndef DMA_CHANNEL_SERVICE_ASSERT_SVH
`define DMA_CHANNEL_SERVICE_ASSERT_SVH

// Checked only outside reset.
`define DCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define DCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/dcs_pkg.sv -----
`timescale 1ns / 1ps

package dcs_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_W       = 3;

   localparam logic [2:0] REQ_SERVICE = 3'd0;
   localparam logic [2:0] REQ_START   = 3'd1;
   localparam logic [2:0] REQ_STOP    = 3'd2;
   localparam logic [2:0] REQ_ATTACH  = 3'd3;
   localparam logic [2:0] REQ_DETACH  = 3'd4;

   localparam logic RES_OK      = 1'b0;
   localparam logic RES_INVALID = 1'b1;

   localparam logic [2:0] UPD_NONE        = 3'd0;
   localparam logic [2:0] UPD_STATUS_IDLE = 3'd1;
   localparam logic [2:0] UPD_STATUS_ZERO = 3'd2;
   localparam logic [2:0] UPD_PARTIAL     = 3'd3;
   localparam logic [2:0] UPD_TERMINAL    = 3'd4;

   localparam logic [15:0] COUNT_RELOAD = 16'hffff;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  channel;
      logic [7:0]  page;
      logic [15:0] cur_addr;
      logic [15:0] cur_count;
      logic [7:0]  mode_byte;
      logic [3:0]  mask_bits;
      logic [7:0]  status_byte;
      logic [16:0] moved_count;
   } req_item_type;

   typedef struct packed {
      logic        result_code;
      logic [23:0] phys_addr;
      logic [16:0] max_items;
      logic [1:0]  xfer_type;
      logic [1:0]  xfer_mode;
      logic        auto_init;
      logic        descending;
      logic [15:0] new_addr;
      logic [15:0] new_count;
      logic [7:0]  new_status;
      logic [2:0]  update_kind;
   } rsp_item_type;

endpackage

// ----- sv/dma_channel_service.sv -----
`timescale 1ns / 1ps
// DMA channel service.
// Request channel: an item (req_data) is taken at a rising edge with start high
// and busy low. It attaches or detaches a handler, starts or stops a channel,
// or services it with a snapshot of the channel's controller registers.
// Result channel: rsp_strobe marks rsp_data for exactly one cycle; the
// receiver cannot stall, so no result is ever held back.
// Pipeline: the item is registered at the accepting edge, worked on in the
// following cycle, and the result is registered at the next edge and driven
// on the ports from that register.
// Throughput: one item per cycle while busy is low; each item's state
// update (flags and the per-channel base registers) lands at the same edge
// as its result, so the next item sees it without a gap.
// Reset: all handler, active and in-progress flags clear, base addresses go to
// zero and base counts to 0xffff. busy is high for the cycle after reset
// and any item in flight is dropped.
module dma_channel_service
   import dcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_strobe,
   output rsp_item_type rsp_data
);

   logic                    busy_ff;
   logic                    req_valid_ff;
   req_item_type            req_ff;
   logic                    rsp_strobe_ff;
   rsp_item_type            rsp_ff;
   rsp_item_type            rsp_in;

   logic [NUM_CHANNELS-1:0] handler_ff, handler_in;
   logic [NUM_CHANNELS-1:0] active_ff, active_in;
   logic [NUM_CHANNELS-1:0] inprog_ff, inprog_in;
   logic [15:0]             base_addr_ff  [NUM_CHANNELS];
   logic [15:0]             base_count_ff [NUM_CHANNELS];
   logic                    base_we;
   logic [15:0]             base_addr_in, base_count_in;

   logic [CHAN_W-1:0] ch;
   logic              ch_ok;
   logic [3:0]        tc_bit;
   logic [7:0]        dreq_bit;
   logic [7:0]        st;
   logic [16:0]       max_items;
   logic [16:0]       moved;
   logic [15:0]       stepped_addr;
   logic [15:0]       b_addr, b_count;

   assign ch        = req_ff.channel;
   assign ch_ok     = {1'b0, ch} < 4'(NUM_CHANNELS);
   assign tc_bit    = 4'b0001 << ch[1:0];
   assign dreq_bit  = {tc_bit, 4'b0000};
   assign max_items = {1'b0, req_ff.cur_count} + 17'd1;
   assign moved     = (req_ff.moved_count > max_items) ? max_items : req_ff.moved_count;
   assign stepped_addr = req_ff.mode_byte[5] ? req_ff.cur_addr - moved[15:0]
                                             : req_ff.cur_addr + moved[15:0];

   always_comb begin
      rsp_in        = '0;
      handler_in    = handler_ff;
      active_in     = active_ff;
      inprog_in     = inprog_ff;
      base_we       = 1'b0;
      base_addr_in  = req_ff.cur_addr;
      base_count_in = req_ff.cur_count;
      st            = req_ff.status_byte;
      b_addr        = '0;
      b_count       = '0;
      if (ch_ok) begin
         b_addr  = base_addr_ff[ch];
         b_count = base_count_ff[ch];
      end

      if (!ch_ok) begin
         rsp_in.result_code = RES_INVALID;
      end else begin
         unique case (req_ff.req_type)
            REQ_ATTACH: begin
               if (handler_ff[ch]) begin
                  rsp_in.result_code = RES_INVALID;
               end else begin
                  handler_in[ch] = 1'b1;
                  active_in[ch]  = 1'b0;
                  inprog_in[ch]  = 1'b0;
                  base_we        = 1'b1;
                  base_addr_in   = '0;
                  base_count_in  = COUNT_RELOAD;
               end
            end
            REQ_START, REQ_STOP, REQ_DETACH: begin
               if (!handler_ff[ch]) begin
                  rsp_in.result_code = RES_INVALID;
               end else begin
                  active_in[ch] = (req_ff.req_type == REQ_START);
                  inprog_in[ch] = 1'b0;
                  if (req_ff.req_type == REQ_DETACH) handler_in[ch] = 1'b0;
               end
            end
            REQ_SERVICE: begin
               if (!handler_ff[ch]) begin
                  rsp_in.result_code = RES_INVALID;
               end else begin
                  rsp_in.new_addr  = req_ff.cur_addr;
                  rsp_in.new_count = req_ff.cur_count;
                  if (!active_ff[ch]) begin
                     rsp_in.new_status  = st & ~dreq_bit;
                     rsp_in.update_kind = UPD_STATUS_IDLE;
                  end else if ((req_ff.mask_bits & tc_bit) != 4'b0000) begin
                     rsp_in.new_status  = st | dreq_bit;
                     rsp_in.update_kind = UPD_STATUS_IDLE;
                  end else begin
                     st = st | dreq_bit;
                     // first unmasked service latches the reload values
                     if (!inprog_ff[ch]) begin
                        base_we       = 1'b1;
                        inprog_in[ch] = 1'b1;
                        b_addr        = req_ff.cur_addr;
                        b_count       = req_ff.cur_count;
                     end
                     rsp_in.phys_addr  = ch[2] ? {req_ff.page, req_ff.cur_addr[14:0], 1'b0}
                                               : {req_ff.page, req_ff.cur_addr};
                     rsp_in.max_items  = max_items;
                     rsp_in.xfer_type  = req_ff.mode_byte[1:0];
                     rsp_in.xfer_mode  = req_ff.mode_byte[7:6];
                     rsp_in.auto_init  = req_ff.mode_byte[4];
                     rsp_in.descending = req_ff.mode_byte[5];
                     if (moved == 17'd0) begin
                        rsp_in.new_status  = st & ~dreq_bit;
                        rsp_in.update_kind = UPD_STATUS_ZERO;
                     end else if (moved > {1'b0, req_ff.cur_count}) begin
                        st = st | {4'b0000, tc_bit};
                        if (req_ff.mode_byte[4]) begin
                           rsp_in.new_addr  = b_addr;
                           rsp_in.new_count = b_count;
                        end else begin
                           st               = st & ~dreq_bit;
                           rsp_in.new_addr  = stepped_addr;
                           rsp_in.new_count = COUNT_RELOAD;
                           active_in[ch]    = 1'b0;
                        end
                        rsp_in.new_status  = st;
                        rsp_in.update_kind = UPD_TERMINAL;
                     end else begin
                        rsp_in.new_addr    = stepped_addr;
                        rsp_in.new_count   = req_ff.cur_count - moved[15:0];
                        rsp_in.new_status  = st;
                        rsp_in.update_kind = UPD_PARTIAL;
                     end
                  end
               end
            end
            default: begin
               rsp_in.result_code = RES_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         handler_ff    <= '0;
         active_ff     <= '0;
         inprog_ff     <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            base_addr_ff[i]  <= '0;
            base_count_ff[i] <= COUNT_RELOAD;
         end
      end else begin
         busy_ff       <= 1'b0;
         req_valid_ff  <= start && !busy_ff;
         rsp_strobe_ff <= req_valid_ff;
         if (req_valid_ff) begin
            handler_ff <= handler_in;
            active_ff  <= active_in;
            inprog_ff  <= inprog_in;
            if (base_we && ch_ok) begin
               base_addr_ff[ch]  <= base_addr_in;
               base_count_ff[ch] <= base_count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) req_ff <= req_data;
      if (req_valid_ff) rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`include "dma_channel_service_assert.svh"

   `DCS_ASSERT(a_result_latency, (start && !busy) |-> ##2 rsp_strobe, "item gave no result")
   `DCS_ASSERT(a_no_spurious, rsp_strobe |-> $past(req_valid_ff), "result without item")
   `DCS_ASSERT(a_update_ok, (rsp_strobe && rsp_data.update_kind != UPD_NONE) |-> (rsp_data.result_code == RES_OK), "write-back on rejected item")
   `DCS_ASSERT(a_idle_no_xfer, (rsp_strobe && rsp_data.update_kind == UPD_STATUS_IDLE) |-> (rsp_data.max_items == 17'd0), "idle service offered a transfer")
   `DCS_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_strobe && busy), "activity after reset")

endmodule

// ----- dv/dma_channel_service_tb.sv -----
`timescale 1ns / 1ps

module dma_channel_service_tb;
   import dcs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 250;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_data;

   dma_channel_service dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // low half first, so the first rising edge comes after time zero
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // shadow of the per-channel state
   logic        drv_attached [NUM_CHANNELS];
   logic        ch_enabled   [NUM_CHANNELS];
   logic        ch_underway  [NUM_CHANNELS];
   logic [15:0] ch_base_addr [NUM_CHANNELS];
   logic [15:0] ch_base_count[NUM_CHANNELS];

   rsp_item_type pending_outcomes[$];
   int error_count = 0;
   int n_sent = 0;
   int n_checked = 0;
   int kind_seen[5] = '{default: 0};
   int cycle_count = 0;
   int idle_pct = 0;

   initial begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         drv_attached[i]  = 1'b0;
         ch_enabled[i]    = 1'b0;
         ch_underway[i]   = 1'b0;
         ch_base_addr[i]  = 16'h0000;
         ch_base_count[i] = COUNT_RELOAD;
      end
   end

   function automatic rsp_item_type service_outcome(req_item_type it);
      rsp_item_type r;
      logic [2:0]   ch;
      logic [1:0]   lane;
      logic [7:0]   tc_bit;
      logic [7:0]   dreq_bit;
      logic [7:0]   st;
      logic [16:0]  span;
      logic [16:0]  moved;
      logic [15:0]  step;
      r = '0;
      ch = it.channel;
      lane = ch[1:0];
      if (it.req_type > REQ_DETACH || int'(ch) >= NUM_CHANNELS) begin
         r.result_code = RES_INVALID;
         return r;
      end
      if (it.req_type == REQ_ATTACH) begin
         if (drv_attached[ch]) begin
            r.result_code = RES_INVALID;
         end else begin
            drv_attached[ch]  = 1'b1;
            ch_enabled[ch]    = 1'b0;
            ch_underway[ch]   = 1'b0;
            ch_base_addr[ch]  = 16'h0000;
            ch_base_count[ch] = COUNT_RELOAD;
         end
         return r;
      end
      if (!drv_attached[ch]) begin
         r.result_code = RES_INVALID;
         return r;
      end
      if (it.req_type == REQ_START) begin
         ch_enabled[ch]  = 1'b1;
         ch_underway[ch] = 1'b0;
         return r;
      end
      if (it.req_type != REQ_SERVICE) begin
         ch_enabled[ch]  = 1'b0;
         ch_underway[ch] = 1'b0;
         if (it.req_type == REQ_DETACH)
            drv_attached[ch] = 1'b0;
         return r;
      end

      tc_bit   = 8'h01 << lane;
      dreq_bit = 8'h10 << lane;
      st       = it.status_byte;
      r.new_addr  = it.cur_addr;
      r.new_count = it.cur_count;
      if (!ch_enabled[ch]) begin
         r.new_status  = st & ~dreq_bit;
         r.update_kind = UPD_STATUS_IDLE;
         return r;
      end
      st = st | dreq_bit;
      if (it.mask_bits[lane]) begin
         r.new_status  = st;
         r.update_kind = UPD_STATUS_IDLE;
         return r;
      end
      if (!ch_underway[ch]) begin
         ch_base_addr[ch]  = it.cur_addr;
         ch_base_count[ch] = it.cur_count;
         ch_underway[ch]   = 1'b1;
      end
      if (ch < 3'd4)
         r.phys_addr = {it.page, it.cur_addr};
      else
         r.phys_addr = {it.page, it.cur_addr[14:0], 1'b0};
      span = {1'b0, it.cur_count} + 17'd1;
      r.max_items  = span;
      r.xfer_type  = it.mode_byte[1:0];
      r.xfer_mode  = it.mode_byte[7:6];
      r.auto_init  = it.mode_byte[4];
      r.descending = it.mode_byte[5];
      moved = (it.moved_count > span) ? span : it.moved_count;
      step  = moved[15:0];
      if (moved == 17'd0) begin
         r.new_status  = st & ~dreq_bit;
         r.update_kind = UPD_STATUS_ZERO;
         return r;
      end
      if (moved > {1'b0, it.cur_count}) begin
         st = st | tc_bit;
         if (it.mode_byte[4]) begin
            r.new_addr  = ch_base_addr[ch];
            r.new_count = ch_base_count[ch];
         end else begin
            st = st & ~dreq_bit;
            r.new_addr  = it.mode_byte[5] ? it.cur_addr - step : it.cur_addr + step;
            r.new_count = COUNT_RELOAD;
            ch_enabled[ch] = 1'b0;
         end
         r.update_kind = UPD_TERMINAL;
      end else begin
         r.new_addr    = it.mode_byte[5] ? it.cur_addr - step : it.cur_addr + step;
         r.new_count   = it.cur_count - step;
         r.update_kind = UPD_PARTIAL;
      end
      r.new_status = st;
      return r;
   endfunction

   task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // predict on acceptance, check on strobe
   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (!reset) begin
         if (start && !busy)
            pending_outcomes.push_back(service_outcome(req_data));
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               $error("unexpected result item: 0x%0h", rsp_data);
               error_count++;
            end else begin
               exp_r = pending_outcomes.pop_front();
               n_checked++;
               if (exp_r.update_kind <= UPD_TERMINAL)
                  kind_seen[exp_r.update_kind]++;
               compare_field("result_code", exp_r.result_code, rsp_data.result_code);
               compare_field("phys_addr", exp_r.phys_addr, rsp_data.phys_addr);
               compare_field("max_items", exp_r.max_items, rsp_data.max_items);
               compare_field("xfer_type", exp_r.xfer_type, rsp_data.xfer_type);
               compare_field("xfer_mode", exp_r.xfer_mode, rsp_data.xfer_mode);
               compare_field("auto_init", exp_r.auto_init, rsp_data.auto_init);
               compare_field("descending", exp_r.descending, rsp_data.descending);
               compare_field("new_addr", exp_r.new_addr, rsp_data.new_addr);
               compare_field("new_count", exp_r.new_count, rsp_data.new_count);
               compare_field("new_status", exp_r.new_status, rsp_data.new_status);
               compare_field("update_kind", exp_r.update_kind, rsp_data.update_kind);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic req_item_type make_req(logic [2:0] kind, logic [2:0] ch,
         logic [7:0] page = 8'h00, logic [15:0] addr = 16'h0000,
         logic [15:0] count = 16'h0000, logic [7:0] mode = 8'h00,
         logic [3:0] mask = 4'h0, logic [7:0] status = 8'h00,
         logic [16:0] moved = 17'd0);
      req_item_type it;
      it.req_type    = kind;
      it.channel     = ch;
      it.page        = page;
      it.cur_addr    = addr;
      it.cur_count   = count;
      it.mode_byte   = mode;
      it.mask_bits   = mask;
      it.status_byte = status;
      it.moved_count = moved;
      return it;
   endfunction

   // start stays high across back-to-back items; only lowered for a gap
   task automatic issue_request(req_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      n_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_no_handler();
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'hff, 16'hffff, 16'hffff, 8'hff,
                             4'hf, 8'hff, 17'h1ffff));
      issue_request(make_req(REQ_START, 3'd0));
      issue_request(make_req(REQ_STOP, 3'd0));
      issue_request(make_req(REQ_DETACH, 3'd0));
   endtask

   task automatic test_bad_request();
      issue_request(make_req(3'd5, 3'd3));
      issue_request(make_req(3'd6, 3'd7, 8'hff, 16'hffff, 16'hffff, 8'hff, 4'hf, 8'hff,
                             17'h1ffff));
      issue_request(make_req(3'd7, 3'd0));
   endtask

   task automatic test_attach();
      issue_request(make_req(REQ_ATTACH, 3'd0));
      issue_request(make_req(REQ_ATTACH, 3'd0));   // duplicate
      // idle channel: DREQ cleared
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h12, 16'h3456, 16'h0010, 8'h55,
                             4'h0, 8'hff, 17'd4));
   endtask

   task automatic test_byte_channel();
      issue_request(make_req(REQ_START, 3'd0));
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h12, 16'h3456, 16'h0010, 8'h55,
                             4'h1, 8'h00, 17'd4));   // masked
      // partial move, address wraps upward; captures base
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'hff, 16'hffff, 16'h0003, 8'hc3,
                             4'he, 8'h00, 17'd2));
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h00, 16'h0001, 16'h0001, 8'h81,
                             4'h0, 8'h0f, 17'd0));   // nothing moved
      // oversized move with auto-init: reload from base
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h01, 16'h0001, 16'h0001, 8'h10,
                             4'h0, 8'h00, 17'h1ffff));
      // full count, descending, no auto-init: channel goes idle
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h80, 16'h0000, 16'hffff, 8'h62,
                             4'h0, 8'h00, 17'h10000));
      issue_request(make_req(REQ_SERVICE, 3'd0, 8'h80, 16'h0000, 16'hffff, 8'h62,
                             4'h0, 8'h10, 17'd1));
   endtask

   task automatic test_word_channel();
      issue_request(make_req(REQ_ATTACH, 3'd7));
      issue_request(make_req(REQ_START, 3'd7));
      issue_request(make_req(REQ_SERVICE, 3'd7, 8'ha5, 16'hffff, 16'h0000, 8'h20,
                             4'h7, 8'h00, 17'd1));
      issue_request(make_req(REQ_STOP, 3'd7));
      issue_request(make_req(REQ_DETACH, 3'd7));
      issue_request(make_req(REQ_DETACH, 3'd7));
      issue_request(make_req(REQ_SERVICE, 3'd7, 8'ha5, 16'h1234, 16'h0004, 8'h01,
                             4'h0, 8'h00, 17'd1));
   endtask

   function automatic req_item_type random_request();
      req_item_type it;
      int unsigned roll;
      it.req_type    = REQ_SERVICE;
      it.channel     = 3'($urandom_range(NUM_CHANNELS - 1));
      it.page        = 8'($urandom);
      it.cur_addr    = 16'($urandom);
      it.cur_count   = ($urandom_range(3) != 0) ? 16'($urandom_range(15)) : 16'($urandom);
      it.mode_byte   = 8'($urandom);
      it.mask_bits   = ($urandom_range(3) != 0) ? 4'h0 : 4'($urandom);
      it.status_byte = 8'($urandom);
      case ($urandom_range(5))
         0: it.moved_count = 17'd0;
         1: it.moved_count = 17'($urandom_range(it.cur_count));
         2: it.moved_count = {1'b0, it.cur_count} + 17'd1;
         3: it.moved_count = 17'($urandom_range(32'h1ffff, it.cur_count + 1));
         4: it.moved_count = 17'($urandom);
         default: it.moved_count = 17'($urandom_range(3));
      endcase
      roll = $urandom_range(99);
      if (roll < 4)
         it.req_type = 3'($urandom_range(7, 5));
      else if (roll < 10)
         it.req_type = REQ_ATTACH;
      else if (roll < 14)
         it.req_type = REQ_DETACH;
      else if (roll < 18)
         it.req_type = REQ_STOP;
      else if (roll < 30)
         it.req_type = REQ_START;
      return it;
   endfunction

   task automatic test_random(int pct);
      idle_pct = pct;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         issue_request(make_req(REQ_ATTACH, 3'(c)));
         issue_request(make_req(REQ_START, 3'(c)));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++)
         issue_request(random_request());
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_no_handler();
      test_bad_request();
      test_attach();
      test_byte_channel();
      test_word_channel();
      wait_drained();
      test_random(0);
      test_random(65);
      test_random(7);
      test_random(0);
      start <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d result items never arrived", pending_outcomes.size());
         error_count++;
      end
      $display("Sent %0d requests across all channels and idle phases; %0d results checked.",
               n_sent, n_checked);
      $display("Update kinds none/idle/zero/partial/terminal: %0d/%0d/%0d/%0d/%0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dcs_pkg.sv
sv/dma_channel_service.sv
dv/dma_channel_service_tb.sv
